### src/kli_pkg.sv
`default_nettype none
package kli_pkg;

  localparam int MAX_KEYFRAMES_DEF = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_EVAL_X = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_PAST      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_INSERTED  = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_FULL      = 3'd5,
    ST_CLEARED   = 3'd6,
    ST_RSVD      = 3'd7
  } status_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        key_time_ms;
    logic signed [63:0] key_value;
    logic [31:0]        elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [63:0] value;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_SHIFT,
    S_SHIFT_WR,
    S_PREV,
    S_MUL_A,
    S_MUL_B,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

  localparam int ProdW = 97;

endpackage
`default_nettype wire

### src/keyframe_linear_interpolator_unit.sv
// Keyframe linear interpolator.
// Input channel in_valid/in_stall/in_data carries a request: clear, insert
// (key_time_ms, key_value) or evaluate (elapsed_ms). The output channel
// out_valid/out_stall/out_data returns exactly one status/value per request.
// The keyframe table is a memory with one read and one write port, so the
// sorted search reads one entry per S_SCAN/S_SCAN_CHK visit and an insert
// shifts one entry per S_SHIFT/S_SHIFT_WR visit. Evaluation forms both
// products through one 32x32 multiplier (four partial products, one per
// cycle) and divides by a restoring divider at one quotient bit per cycle
// over 97 bits. One request is in work at a time; in_stall is high from
// acceptance until its result is taken.
// A stalled result holds on out_data until out_stall drops.
// Reset empties the table; stored entries are not cleared.
`default_nettype none
module keyframe_linear_interpolator_unit #(
  parameter int MAX_KEYFRAMES = kli_pkg::MAX_KEYFRAMES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kli_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kli_pkg::out_item_t     out_data
);
  import kli_pkg::*;

  localparam int IW = $clog2(MAX_KEYFRAMES);
  localparam int CW = $clog2(MAX_KEYFRAMES + 1);
  localparam int DCW = $clog2(ProdW + 1);

  logic [31:0] times_mem [MAX_KEYFRAMES];
  logic [63:0] vals_mem  [MAX_KEYFRAMES];

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  in_item_t req_r;
  logic [31:0] rd_time_r;
  logic [63:0] rd_val_r;
  logic [IW-1:0] rd_addr;
  logic we;
  logic [IW-1:0] wr_addr;
  logic [31:0] wr_time;
  logic [63:0] wr_val;

  logic [31:0] tprev_r, tprev_nxt;
  logic [63:0] vprev_r, vprev_nxt;
  logic [31:0] tcur_r, tcur_nxt;
  logic [63:0] vcur_r, vcur_nxt;
  logic [ProdW-1:0] acc_r, acc_nxt;
  logic [ProdW-1:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic neg_r, neg_nxt;
  out_item_t res_r, res_nxt;

  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_mag;
  logic [31:0] mul_half;
  logic [63:0] mul_p;
  logic [ProdW-1:0] mul_ext;
  logic [ProdW-1:0] mul_s;
  logic [31:0] den;
  logic [32:0] rem_sh;
  logic [ProdW-1:0] quo_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_time_r <= times_mem[rd_addr];
    rd_val_r  <= vals_mem[rd_addr];
    if (we) begin
      times_mem[wr_addr] <= wr_time;
      vals_mem[wr_addr]  <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      req_r <= in_data;
    end
    pos_r   <= pos_nxt;
    tprev_r <= tprev_nxt;
    vprev_r <= vprev_nxt;
    tcur_r  <= tcur_nxt;
    vcur_r  <= vcur_nxt;
    acc_r   <= acc_nxt;
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    neg_r   <= neg_nxt;
    res_r   <= res_nxt;
  end

  assign den = tcur_r - tprev_r;
  assign mul_mag = mul_a[63] ? (64'd0 - mul_a) : mul_a;
  assign mul_half = dcnt_r[0] ? mul_mag[63:32] : mul_mag[31:0];
  assign mul_p = mul_half * mul_b;
  assign mul_ext = dcnt_r[0] ? {1'b0, mul_p, 32'd0} : {33'd0, mul_p};
  assign mul_s = mul_a[63] ? (ProdW'(0) - mul_ext) : mul_ext;
  assign rem_sh = {rem_r[31:0], acc_r[ProdW-1]};
  assign quo_neg = ProdW'(0) - quo_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    tprev_nxt = tprev_r;
    vprev_nxt = vprev_r;
    tcur_nxt  = tcur_r;
    vcur_nxt  = vcur_r;
    acc_nxt   = acc_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    rd_addr   = pos_r[IW-1:0];
    we        = 1'b0;
    wr_addr   = pos_r[IW-1:0];
    wr_time   = req_r.key_time_ms;
    wr_val    = req_r.key_value;
    mul_a     = dcnt_r[1] ? vcur_r : vprev_r;
    mul_b     = dcnt_r[1] ? (req_r.elapsed_ms - tprev_r)
                          : (den - (req_r.elapsed_ms - tprev_r));
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        pos_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        res_nxt.value = '0;
        if (req_r.command == CMD_CLEAR) begin
          count_nxt = '0;
          res_nxt.status = ST_CLEARED;
          state_nxt = S_OUT;
        end else if (req_r.command != CMD_INSERT && count_r == '0) begin
          res_nxt.status = ST_EMPTY;
          state_nxt = S_OUT;
        end else if (pos_r >= count_r) begin
          if (req_r.command == CMD_INSERT) begin
            if (count_r >= CW'(MAX_KEYFRAMES)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              tprev_nxt = {{(32-CW){1'b0}}, count_r};
              pos_nxt = count_r;
              state_nxt = S_SHIFT;
            end
          end else begin
            res_nxt.status = ST_PAST;
            state_nxt = S_OUT;
          end
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        tcur_nxt = rd_time_r;
        vcur_nxt = rd_val_r;
        if (req_r.command == CMD_INSERT) begin
          if (rd_time_r == req_r.key_time_ms) begin
            res_nxt.status = ST_DUPLICATE;
            state_nxt = S_OUT;
          end else if (rd_time_r > req_r.key_time_ms) begin
            if (count_r >= CW'(MAX_KEYFRAMES)) begin
              res_nxt.status = ST_FULL;
              state_nxt = S_OUT;
            end else begin
              dcnt_nxt = DCW'(0);
              tprev_nxt = {{(32-CW){1'b0}}, pos_r};
              pos_nxt = count_r;
              state_nxt = S_SHIFT;
            end
          end else begin
            pos_nxt = pos_r + 1'b1;
            state_nxt = S_SCAN;
          end
        end else begin
          if (req_r.elapsed_ms > rd_time_r) begin
            pos_nxt = pos_r + 1'b1;
            state_nxt = S_SCAN;
          end else if (pos_r == '0) begin
            res_nxt.status = ST_VALID;
            res_nxt.value = rd_val_r;
            state_nxt = S_OUT;
          end else begin
            pos_nxt = pos_r - 1'b1;
            state_nxt = S_PREV;
          end
        end
      end
      S_SHIFT: begin
        // pos_r is the slot being filled; tprev_r low bits hold the target
        if (pos_r == tprev_r[CW-1:0] || pos_r == '0) begin
          we = 1'b1;
          count_nxt = count_r + 1'b1;
          res_nxt.status = ST_INSERTED;
          res_nxt.value = '0;
          state_nxt = S_OUT;
        end else begin
          rd_addr = IW'(pos_r - 1'b1);
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        wr_time = rd_time_r;
        wr_val = rd_val_r;
        pos_nxt = pos_r - 1'b1;
        state_nxt = S_SHIFT;
      end
      S_PREV: begin
        dcnt_nxt = DCW'(0);
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        tprev_nxt = rd_time_r;
        vprev_nxt = rd_val_r;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        // accumulate prev*(den-num) then cur*num, low half then high half
        if (dcnt_r == DCW'(0)) begin
          acc_nxt = mul_s;
        end else begin
          acc_nxt = acc_r + mul_s;
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(3)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        neg_nxt = acc_r[ProdW-1];
        if (acc_r[ProdW-1]) begin
          acc_nxt = ProdW'(0) - acc_r;
        end
        rem_nxt = '0;
        quo_nxt = '0;
        dcnt_nxt = DCW'(ProdW);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dcnt_r == DCW'(0)) begin
          res_nxt.status = ST_VALID;
          res_nxt.value = neg_r ? quo_neg[63:0] : quo_r[63:0];
          state_nxt = S_OUT;
        end else begin
          acc_nxt = {acc_r[ProdW-2:0], 1'b0};
          if (rem_sh >= {1'b0, den}) begin
            rem_nxt = rem_sh - {1'b0, den};
            quo_nxt = {quo_r[ProdW-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh;
            quo_nxt = {quo_r[ProdW-2:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_data = res_r;

endmodule
`default_nettype wire
